FILE: design/vlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and constants for the 32/64-bit varint codec: result kinds,
// group and limit constants, and the control word of the shift unit.
// ----------------------------------------------------------------------------
package vlc_pkg;

	// field widths
	localparam int VALUE_W   = 64;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int POS_W     = 7;
	localparam int SHAMT_W   = 6;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// group layout
	localparam int unsigned GROUP_BITS = 7;
	localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
	localparam logic [BYTE_W-1:0] DATA_MASK = 8'h7f;

	// most continuation bytes in one encoding
	localparam logic [3:0] ENC_MAX_CONT = 4'd9;

	// action codes
	localparam logic ACT_DECODE = 1'b0;
	localparam logic ACT_ENCODE = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// register index of long_mode
	localparam logic REG_LONG_MODE = 1'b0;

	// shift direction
	localparam logic SHIFT_LEFT  = 1'b0;
	localparam logic SHIFT_RIGHT = 1'b1;

	// shift unit control
	typedef struct packed {
		logic               dir;
		logic [SHAMT_W-1:0] amount;
	} shift_ctl_t;

endpackage

FILE: design/vlc_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_cmd_if
// Request channel of the varint codec: action, byte to decode, value to encode.
// ----------------------------------------------------------------------------
interface vlc_cmd_if
	import vlc_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [BYTE_W-1:0]          in_byte;
	logic signed [VALUE_W-1:0]  in_value;

	modport source (output valid, action, in_byte, in_value, input ready);
	modport sink   (input valid, action, in_byte, in_value, output ready);
endinterface

FILE: design/vlc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_res_if
// Result channel of the varint codec: kind, encoded byte, decoded value, last.
// ----------------------------------------------------------------------------
interface vlc_res_if
	import vlc_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic [BYTE_W-1:0]          out_byte;
	logic signed [VALUE_W-1:0]  out_value;
	logic                       last;

	modport source (output valid, kind, out_byte, out_value, last, input ready);
	modport sink   (input valid, kind, out_byte, out_value, last, output ready);
endinterface

FILE: design/vlc_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_shift
// Shared 64-bit shifter: left by the bit position when decoding, right by one
// group when encoding.
// ----------------------------------------------------------------------------
module vlc_shift
	import vlc_pkg::*;
(
	input  shift_ctl_t          ctl,
	input  logic [VALUE_W-1:0]  operand,
	output logic [VALUE_W-1:0]  result
);

	// logical shift in either direction
	always_comb begin
		if (ctl.dir == SHIFT_RIGHT) begin
			result = operand >> ctl.amount;
		end else begin
			result = operand << ctl.amount;
		end
	end

endmodule

FILE: design/varint_codec_32_64_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_codec_32_64_top
// Unsigned LEB128 codec, 32-bit or 64-bit mode. Decodes one byte a request,
// encodes one value a request into 1 to 10 bytes through one shared shifter.
// ----------------------------------------------------------------------------
// decode: the byte passes through the shifter in ST_DEC; a result is registered only for the last
//   byte of a value or on overflow, once the result slot is free; no new byte is taken until then
// encode of n bytes: n work steps, one byte a cycle through the shifter while the result slot is free;
//   the result side's ready paces each byte, and no new request is taken until the last byte
// reset: long_mode 0 (32-bit), decoder cleared, no result pending
module varint_codec_32_64_top
	import vlc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	vlc_cmd_if.sink                cmd,
	vlc_res_if.source              res
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEC  = 2'd1;
	localparam logic [1:0] ST_ENC  = 2'd2;

	logic [1:0]          state_q;
	logic                long_mode_q;
	logic [VALUE_W-1:0]  acc_q;
	logic [POS_W-1:0]    pos_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [VALUE_W-1:0]  val_q;
	logic [3:0]          cnt_q;

	logic                res_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [BYTE_W-1:0]   obyte_q;
	logic [VALUE_W-1:0]  oval_q;
	logic                last_q;

	shift_ctl_t          sh_ctl;
	logic [VALUE_W-1:0]  sh_in;
	logic [VALUE_W-1:0]  sh_out;

	logic                slot_free;
	logic                cmd_fire;
	logic                cfg_wr;
	logic [VALUE_W-1:0]  acc_or;
	logic [VALUE_W-1:0]  dec_value;
	logic [POS_W-1:0]    pos_next;
	logic                dec_ovf;
	logic                enc_more;
	logic [BYTE_W-1:0]   enc_byte;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_LONG_MODE);
	assign prdata = (paddr[2] == REG_LONG_MODE) ?
		{{(APB_DATA_W-1){1'b0}}, long_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			long_mode_q <= pwdata[0];
		end
	end

	// handshakes
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid & cmd.ready;
	assign slot_free = ~res_valid_q | res.ready;

	// shared shifter control
	always_comb begin
		if (state_q == ST_ENC) begin
			sh_ctl.dir    = SHIFT_RIGHT;
			sh_ctl.amount = SHAMT_W'(GROUP_BITS);
			sh_in         = val_q;
		end else begin
			sh_ctl.dir    = SHIFT_LEFT;
			sh_ctl.amount = pos_q[SHAMT_W-1:0];
			sh_in         = {{(VALUE_W-BYTE_W){1'b0}}, byte_q & DATA_MASK};
		end
	end

	vlc_shift u_shift (
		.ctl     (sh_ctl),
		.operand (sh_in),
		.result  (sh_out)
	);

	// decode step
	assign acc_or   = acc_q | sh_out;
	assign pos_next = pos_q + POS_W'(GROUP_BITS);
	assign dec_ovf  = long_mode_q ? pos_next[6] : (pos_next[6] | pos_next[5]);
	assign dec_value = long_mode_q ? acc_or :
		{{(VALUE_W/2){acc_or[VALUE_W/2-1]}}, acc_or[VALUE_W/2-1:0]};

	// encode step
	assign enc_more = (|val_q[VALUE_W-1:GROUP_BITS]) && (cnt_q < ENC_MAX_CONT);
	assign enc_byte = enc_more ? ((val_q[BYTE_W-1:0] & DATA_MASK) | CONT_MARK)
		: val_q[BYTE_W-1:0];

	// sequencer and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						cnt_q <= '0;
						state_q <= (cmd.action == ACT_ENCODE) ? ST_ENC : ST_DEC;
					end
				end
				ST_DEC: begin
					if (byte_q[7] == 1'b0 || dec_ovf) begin
						if (slot_free) begin
							acc_q   <= '0;
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						acc_q   <= acc_or;
						pos_q   <= pos_next;
						state_q <= ST_IDLE;
					end
				end
				ST_ENC: begin
					if (slot_free) begin
						cnt_q <= cnt_q + 4'd1;
						if (!enc_more) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and encode shift register
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			byte_q <= cmd.in_byte;
			val_q  <= long_mode_q ? cmd.in_value :
				{{(VALUE_W/2){1'b0}}, cmd.in_value[VALUE_W/2-1:0]};
		end else if (state_q == ST_ENC && slot_free) begin
			val_q <= sh_out;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (slot_free) begin
			res_valid_q <= (state_q == ST_ENC) ||
				(state_q == ST_DEC && (byte_q[7] == 1'b0 || dec_ovf));
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			priority if (state_q == ST_ENC) begin
				kind_q  <= KIND_BYTE;
				obyte_q <= enc_byte;
				oval_q  <= '0;
				last_q  <= ~enc_more;
			end else if (byte_q[7] == 1'b0) begin
				kind_q  <= KIND_VALUE;
				obyte_q <= '0;
				oval_q  <= dec_value;
				last_q  <= 1'b1;
			end else begin
				kind_q  <= KIND_ERROR;
				obyte_q <= '0;
				oval_q  <= '0;
				last_q  <= 1'b1;
			end
		end
	end

	// result channel
	assign res.valid     = res_valid_q;
	assign res.kind      = kind_q;
	assign res.out_byte  = obyte_q;
	assign res.out_value = oval_q;
	assign res.last      = last_q;

endmodule
